// ===== rtl/core/fcb_pkg.sv =====
// Shared types, action codes and helper functions for the free-cluster bitmap.
// Used by every module of the block; has no dependencies of its own.
package fcb_pkg;

  localparam int INDEX_W     = 14;
  localparam int WORD_BITS   = 64;
  localparam int BIT_W       = 6;
  localparam int INDEX_LIMIT = 16384;
  localparam int QUEUE_DEPTH = 2;

  // Action codes as they arrive on the request channel.
  localparam logic [2:0] ACT_MARK_FREE = 3'd0;
  localparam logic [2:0] ACT_MARK_USED = 3'd1;
  localparam logic [2:0] ACT_QUERY     = 3'd2;
  localparam logic [2:0] ACT_FIND      = 3'd3;
  localparam logic [2:0] ACT_FORMAT    = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [INDEX_W-1:0] cluster_index;
  } req_t;

  typedef struct packed {
    logic               is_free;
    logic [INDEX_W-1:0] found_index;
    logic               none_free;
  } rsp_t;

  // Internal operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_MARK_FREE,
    OP_MARK_USED,
    OP_QUERY,
    OP_FIND,
    OP_FORMAT,
    OP_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic               in_range;
    logic [INDEX_W-1:0] cluster_index;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Position of the lowest set bit of a map word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/fcb_front.sv =====
// Front end of the free-cluster bitmap: classifies requests and queues them.
// Depends on fcb_pkg for the request and command types.
module fcb_front #(
  parameter int NUM_CLUSTERS = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  fcb_pkg::req_t        req,
  input  fcb_pkg::back_status_t status,
  output logic                 cmd_valid,
  input  logic                 cmd_pop,
  output fcb_pkg::cmd_t        cmd
);
  import fcb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             cmd_in;
  logic             push;
  logic             pop;

  // Decode the action and check the index against the map size.
  always_comb begin
    cmd_in.cluster_index = req.cluster_index;
    cmd_in.in_range      = (32'(req.cluster_index) < NUM_CLUSTERS);
    unique case (req.action)
      ACT_MARK_FREE: cmd_in.op = OP_MARK_FREE;
      ACT_MARK_USED: cmd_in.op = OP_MARK_USED;
      ACT_QUERY:     cmd_in.op = OP_QUERY;
      ACT_FIND:      cmd_in.op = OP_FIND;
      ACT_FORMAT:    cmd_in.op = OP_FORMAT;
      default:       cmd_in.op = OP_NOP;
    endcase
  end

  assign req_stall = (count == CNT_W'(QUEUE_DEPTH)) || status.clearing;
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= cmd_in;
        wr_ptr        <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/fcb_back.sv =====
// Back end of the free-cluster bitmap: map memory, operation sequencer and result register.
// Depends on fcb_pkg for the command, result and status types.
module fcb_back #(
  parameter int NUM_CLUSTERS = 16384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  fcb_pkg::cmd_t         cmd,
  output fcb_pkg::back_status_t status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output fcb_pkg::rsp_t         rsp
);
  import fcb_pkg::*;

  localparam int MAP_WORDS  = (NUM_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIMIT_WORDS = INDEX_LIMIT / WORD_BITS;
  localparam int SCAN_WORDS = (MAP_WORDS < LIMIT_WORDS) ? MAP_WORDS : LIMIT_WORDS;
  localparam int LAST_BITS  = NUM_CLUSTERS - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_BITS >= WORD_BITS) ?
      {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [AW-1:0] SCAN_LAST = AW'(SCAN_WORDS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WAIT = 6'b000010,
    S_SCAN = 6'b000100,
    S_FMT  = 6'b001000,
    S_RESP = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  cmd_t                 cur;
  rsp_t                 res;
  logic [AW-1:0]        fmt_addr;
  logic                 fmt_reply;
  logic [AW-1:0]        scan_addr;
  logic [AW-1:0]        chk_addr;
  logic                 chk_valid;
  logic                 rsp_load;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  logic [AW-1:0]        head_word;
  logic [AW-1:0]        cur_word;
  logic [BIT_W-1:0]     cur_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] fmt_word;
  logic [WORD_BITS-1:0] scan_word;
  logic                 hit;
  logic [INDEX_W-1:0]   found;

  assign head_word = AW'(32'(cmd.cluster_index) >> BIT_W);
  assign cur_word  = AW'(32'(cur.cluster_index) >> BIT_W);
  assign cur_bit   = cur.cluster_index[BIT_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << cur_bit;

  // Clusters 0 and 1 are reserved: used after format, skipped by the search.
  always_comb begin
    fmt_word = (fmt_addr == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
    if (fmt_addr == '0) begin
      fmt_word[1:0] = 2'b00;
    end
    scan_word = rdata;
    if (chk_addr == '0) begin
      scan_word[1:0] = 2'b00;
    end
  end

  assign hit   = chk_valid && (scan_word != '0);
  assign found = INDEX_W'((32'(chk_addr) << BIT_W) | 32'(lowest_set(scan_word)));

  assign status.clearing = (state == S_FMT) && !fmt_reply;

  // The result moves into the response register once that register is free
  // or is being emptied in the same cycle.
  assign rsp_load = ((state == S_RESP) || (state == S_HOLD)) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    raddr      = scan_addr;
    we         = 1'b0;
    waddr      = cur_word;
    wdata      = rdata;
    cmd_pop    = 1'b0;
    unique case (state)
      S_IDLE: begin
        raddr = head_word;
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op) inside
            OP_MARK_FREE, OP_MARK_USED, OP_QUERY:
              state_next = cmd.in_range ? S_WAIT : S_RESP;
            OP_FIND:   state_next = S_SCAN;
            OP_FORMAT: state_next = S_FMT;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_WAIT: begin
        if (cur.op == OP_MARK_FREE) begin
          we    = 1'b1;
          wdata = rdata | bit_mask;
        end else if (cur.op == OP_MARK_USED) begin
          we    = 1'b1;
          wdata = rdata & ~bit_mask;
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (hit || (chk_valid && chk_addr == SCAN_LAST)) begin
          state_next = S_RESP;
        end
      end
      S_FMT: begin
        we    = 1'b1;
        waddr = fmt_addr;
        wdata = fmt_word;
        if (fmt_addr == LAST_WORD) begin
          state_next = fmt_reply ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        state_next = (!rsp_valid || !rsp_stall) ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FMT;
      fmt_addr  <= '0;
      fmt_reply <= 1'b0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur       <= cmd;
            res       <= '0;
            fmt_addr  <= '0;
            fmt_reply <= 1'b1;
            scan_addr <= '0;
            chk_valid <= 1'b0;
          end
        end
        S_WAIT: begin
          if (cur.op == OP_QUERY) begin
            res.is_free <= rdata[cur_bit];
          end
        end
        S_SCAN: begin
          chk_addr  <= scan_addr;
          chk_valid <= 1'b1;
          if (scan_addr != SCAN_LAST) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (hit) begin
            res.found_index <= found;
          end else if (chk_valid && chk_addr == SCAN_LAST) begin
            res.none_free <= 1'b1;
          end
        end
        S_FMT: begin
          fmt_addr <= fmt_addr + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/free_cluster_bitmap.sv =====
// Top level of the free-cluster bitmap allocator.
// Depends on fcb_pkg, fcb_front and fcb_back.
//
// The block keeps one bit per storage cluster; a set bit means the cluster is
// free. Each request transfer carries an action and a cluster index: mark
// free, mark used, query, find the lowest free cluster at index 2 or above,
// or format. Every request gives exactly one response transfer, in order.
// Both channels use valid and stall; a transfer happens on a rising edge with
// valid high and stall low.
// The front end classifies requests into a two-entry command queue, so it
// keeps taking requests while the back end works or its response waits.
// The back end owns the map memory, one 64-bit word per 64 clusters, with a
// single write port and a registered read port; that port sets the latency.
// Mark and query pass from the queue head through the idle, wait and response
// states into the response register. Find reads one word per cycle, and
// format writes one word per cycle.
// Reset starts a clearing pass that writes the formatted map, one word per
// cycle over all MAP_WORDS words (256 by default); request stall stays high
// until it ends. No response comes out of the clearing pass.
// When the receiver stalls, the response register holds its value and the
// back end waits with the next result while the queue keeps filling.
module free_cluster_bitmap #(
  parameter int NUM_CLUSTERS = 16384
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fcb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fcb_pkg::rsp_t rsp
);
  import fcb_pkg::*;

  // Classified commands travel from the front end to the back end here.
  logic         cmd_valid;
  logic         cmd_pop;
  cmd_t         cmd;
  back_status_t status;

  // The front end takes requests, checks the index against the map size and
  // queues them.
  fcb_front #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .status    (status),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // The back end runs one command at a time against the map memory and
  // delivers the result through its response register.
  fcb_back #(
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/fcb_checker.sv =====
// Port-level checks for the free-cluster bitmap, bound to the top level.
// Depends on fcb_pkg and free_cluster_bitmap.
module fcb_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input fcb_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input fcb_pkg::rsp_t rsp
);
  import fcb_pkg::*;

  // The clearing pass after reset refuses requests.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted during the clearing pass");

  // Reset never lets a response out in the following cycle.
  a_no_rsp_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response right after reset");

  // A stalled request stays offered and unchanged.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // A stalled response stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A result answers one action only, and a found index is never 1.
  a_rsp_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_free && (rsp.none_free || rsp.found_index != '0))
                  && !(rsp.none_free && rsp.found_index != '0)
                  && (rsp.found_index != INDEX_W'(1)))
    else $error("inconsistent response fields");

endmodule

bind free_cluster_bitmap fcb_checker u_fcb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== verif/tb_free_cluster_bitmap.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the free-cluster bitmap allocator top level.
// Depends on fcb_pkg for the request and response types and the action codes.
module tb_free_cluster_bitmap;
  import fcb_pkg::*;

  // The map size under test. Every cluster index that fits the 14-bit field
  // exists at this size, so the search covers the whole map.
  localparam int NUM_CLUSTERS = 16384;
  localparam int MAP_WORDS    = (NUM_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int SEARCH_END   = (NUM_CLUSTERS < INDEX_LIMIT) ? NUM_CLUSTERS : INDEX_LIMIT;

  localparam int RANDOM_ITEMS = 825;
  localparam int HOLD_CYCLES  = 400;   // long response hold-off in the last phase
  localparam int DRAIN_CYCLES = 300;   // a little more than the longest find
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int REPORT_MAX   = 10;

  // Action codes 5 to 7 have no meaning; the block must answer them with zeros.
  localparam logic [2:0] ACT_UNUSED_A = 3'd5;
  localparam logic [2:0] ACT_UNUSED_B = 3'd6;
  localparam logic [2:0] ACT_UNUSED_C = 3'd7;

  // Responses that can be read straight off the behavior.
  localparam rsp_t NO_DATA    = '0;
  localparam rsp_t SHOWS_FREE = '{is_free: 1'b1, found_index: '0, none_free: 1'b0};
  localparam rsp_t FOUND_TWO  = '{is_free: 1'b0, found_index: 14'd2, none_free: 1'b0};

  typedef struct {
    logic [2:0]  action;
    int unsigned index;
    bit          has_exp;
    rsp_t        exp;
  } vector_t;

  localparam int DIRECTED_N = 25;

  // Directed opening. Rows with has_exp set carry a response typed in by
  // hand; the others take the response that the local map model predicts.
  vector_t directed_vec [DIRECTED_N] = '{
    // Reset state: clusters 0 and 1 used, everything else free.
    '{ACT_QUERY,     0,      1'b1, NO_DATA},
    '{ACT_QUERY,     1,      1'b1, NO_DATA},
    '{ACT_QUERY,     2,      1'b1, SHOWS_FREE},
    '{ACT_QUERY,     16383,  1'b1, SHOWS_FREE},
    '{ACT_FIND,      16383,  1'b1, FOUND_TWO},
    // Format on top of a formatted map changes nothing.
    '{ACT_FORMAT,    0,      1'b1, NO_DATA},
    '{ACT_MARK_USED, 2,      1'b1, NO_DATA},
    '{ACT_FIND,      0,      1'b0, NO_DATA},
    // Top cluster, used then queried.
    '{ACT_MARK_USED, 16383,  1'b1, NO_DATA},
    '{ACT_QUERY,     16383,  1'b1, NO_DATA},
    // Freeing clusters 0 and 1 must not draw the search below cluster 2.
    '{ACT_MARK_FREE, 0,      1'b1, NO_DATA},
    '{ACT_QUERY,     0,      1'b1, SHOWS_FREE},
    '{ACT_MARK_FREE, 1,      1'b1, NO_DATA},
    '{ACT_MARK_USED, 3,      1'b1, NO_DATA},
    '{ACT_FIND,      14'h2AAA, 1'b0, NO_DATA},
    // Unused actions answer zeros and leave the map alone.
    '{ACT_UNUSED_A,  16383,  1'b1, NO_DATA},
    '{ACT_UNUSED_B,  14'h1555, 1'b1, NO_DATA},
    '{ACT_UNUSED_C,  14'h2AAA, 1'b1, NO_DATA},
    '{ACT_QUERY,     3,      1'b0, NO_DATA},
    '{ACT_MARK_FREE, 16383,  1'b1, NO_DATA},
    // Format restores the reset picture, whatever the index field holds.
    '{ACT_FORMAT,    16383,  1'b1, NO_DATA},
    '{ACT_QUERY,     0,      1'b1, NO_DATA},
    '{ACT_QUERY,     3,      1'b1, SHOWS_FREE},
    '{ACT_FIND,      14'h1555, 1'b1, FOUND_TWO},
    '{ACT_QUERY,     16383,  1'b1, SHOWS_FREE}
  };

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  free_cluster_bitmap #(
    .NUM_CLUSTERS(NUM_CLUSTERS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Local copy of the free map, one 64-bit word per 64 clusters, and the
  // responses it has predicted that the block has not delivered yet.
  logic [WORD_BITS-1:0] free_words [MAP_WORDS];
  rsp_t                 pending_rsp_q [$];

  int          snd_idle_pct   = 34;
  int          rcv_idle_pct   = 73;
  bit          pressure_go    = 1'b0;
  int          hold_count     = 0;
  int          input_blocked  = 0;
  int          items_sent     = 0;
  int          rsp_checked    = 0;
  int          fault_count    = 0;
  int          finds_none     = 0;
  int unsigned top_found      = 0;
  int unsigned cycle_count    = 0;
  rsp_t        head_rsp;

  // Formatted map: every existing cluster free, then clusters 0 and 1 used.
  function automatic void format_map_model();
    for (int w = 0; w < MAP_WORDS; w++) begin
      if (NUM_CLUSTERS - w * WORD_BITS >= WORD_BITS) begin
        free_words[w] = '1;
      end else begin
        free_words[w] = (64'd1 << (NUM_CLUSTERS - w * WORD_BITS)) - 64'd1;
      end
    end
    free_words[0][1:0] = 2'b00;
  endfunction

  // Applies one request to the local map and returns the response it causes.
  // Indexes outside the map are ignored by marks and read as used by queries.
  function automatic rsp_t bitmap_apply(input req_t item);
    rsp_t        r;
    int unsigned idx;
    r   = '0;
    idx = item.cluster_index;
    case (item.action)
      ACT_MARK_FREE: begin
        if (idx < NUM_CLUSTERS) free_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
      end
      ACT_MARK_USED: begin
        if (idx < NUM_CLUSTERS) free_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      end
      ACT_QUERY: begin
        if (idx < NUM_CLUSTERS) r.is_free = free_words[idx / WORD_BITS][idx % WORD_BITS];
      end
      ACT_FIND: begin
        // Lowest free cluster from 2 upward; none_free stays set if none.
        r.none_free = 1'b1;
        for (int c = 2; c < SEARCH_END && r.none_free; c++) begin
          if (free_words[c / WORD_BITS][c % WORD_BITS]) begin
            r.found_index = INDEX_W'(c);
            r.none_free   = 1'b0;
          end
        end
      end
      ACT_FORMAT: begin
        format_map_model();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_fault(input string what, input rsp_t want, input rsp_t got);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("[%0t] %s: expected is_free=%0b found_index=%0d none_free=%0b,",
               $time, what, want.is_free, want.found_index, want.none_free);
      $display("    got is_free=%0b found_index=%0d none_free=%0b",
               got.is_free, got.found_index, got.none_free);
    end
  endtask

  // Offers one request, after a random number of idle cycles, and holds it
  // until the block takes it. The response is predicted at the transfer edge
  // so the model sees requests in exactly the order the block does. Called
  // right after a rising edge; returns right after the transfer edge.
  task automatic send_req(input logic [2:0] action, input int unsigned index,
                          output rsp_t predicted);
    req_t item;
    item.action        = action;
    item.cluster_index = INDEX_W'(index);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predicted = bitmap_apply(item);
    pending_rsp_q.push_back(predicted);
    items_sent++;
    if (action == ACT_FIND) begin
      if (predicted.none_free) finds_none++;
      if (predicted.found_index > top_found) top_found = predicted.found_index;
    end
  endtask

  // Response side: checks every transfer against the oldest prediction and
  // drives the stall, either at random or as one long hold-off that lets the
  // command queue fill until the block stalls its request channel.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          report_fault("response with no request outstanding", NO_DATA, rsp);
        end else begin
          head_rsp = pending_rsp_q.pop_front();
          rsp_checked++;
          if (rsp.is_free !== head_rsp.is_free || rsp.found_index !== head_rsp.found_index ||
              rsp.none_free !== head_rsp.none_free) begin
            report_fault("response mismatch", head_rsp, rsp);
          end
        end
      end
      if (pressure_go && hold_count < HOLD_CYCLES) begin
        rsp_stall  <= 1'b1;
        hold_count <= hold_count + 1;
        if (req_valid && req_stall) input_blocked++;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d responses still outstanding",
               cycle_count, pending_rsp_q.size());
      $display("tb_free_cluster_bitmap failed");
      $finish;
    end
  end

  initial begin
    rsp_t        pred;
    int unsigned claimed;
    int unsigned pick;
    int unsigned k;
    int unsigned held_q [$];

    format_map_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass now; the request stall holds the
    // first transfer off until the pass is done.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_req(directed_vec[i].action, directed_vec[i].index, pred);
      // The response cannot leave the block at the transfer edge itself, so
      // the newest prediction is still at the back of the queue here.
      if (directed_vec[i].has_exp) pending_rsp_q[$] = directed_vec[i].exp;
    end

    // Random part. Most of it follows the way a file system uses the map:
    // find a free cluster, then claim it; later free a claimed one again.
    // Stray marks anywhere in the map, lone finds, finds that are never
    // claimed, unused actions and the odd format make up the rest.
    while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
      // Idling goes through three phases: slow receiver, slow sender, none.
      if (items_sent < DIRECTED_N + RANDOM_ITEMS / 3) begin
        snd_idle_pct = 34;
        rcv_idle_pct <= 73;
      end else if (items_sent < DIRECTED_N + 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 73;
        rcv_idle_pct <= 34;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        pressure_go  <= 1'b1;
      end
      k = $urandom_range(0, 99);
      if (k < 35) begin
        send_req(ACT_FIND, $urandom_range(0, INDEX_LIMIT - 1), pred);
        if (!pred.none_free) begin
          claimed = pred.found_index;
          send_req(ACT_MARK_USED, claimed, pred);
          held_q.push_back(claimed);
        end
      end else if (k < 55) begin
        if (held_q.size() > 0) begin
          pick = $urandom_range(0, held_q.size() - 1);
          send_req(ACT_MARK_FREE, held_q[pick], pred);
          held_q.delete(pick);
        end else begin
          send_req(ACT_MARK_FREE, $urandom_range(0, INDEX_LIMIT - 1), pred);
        end
      end else if (k < 70) begin
        if (held_q.size() > 0 && $urandom_range(0, 1)) begin
          send_req(ACT_QUERY, held_q[$urandom_range(0, held_q.size() - 1)], pred);
        end else begin
          send_req(ACT_QUERY, $urandom_range(0, INDEX_LIMIT - 1), pred);
        end
      end else if (k < 80) begin
        send_req($urandom_range(0, 1) ? ACT_MARK_USED : ACT_MARK_FREE,
                 $urandom_range(0, INDEX_LIMIT - 1), pred);
      end else if (k < 87) begin
        send_req(ACT_FIND, $urandom_range(0, INDEX_LIMIT - 1), pred);
      end else if (k < 92) begin
        send_req(3'(ACT_UNUSED_A + $urandom_range(0, 2)),
                 $urandom_range(0, INDEX_LIMIT - 1), pred);
      end else if (k < 96) begin
        // Broken allocation: the found cluster is only looked at, never taken.
        send_req(ACT_FIND, $urandom_range(0, INDEX_LIMIT - 1), pred);
        send_req(ACT_QUERY, pred.found_index, pred);
      end else begin
        send_req(ACT_FORMAT, $urandom_range(0, INDEX_LIMIT - 1), pred);
        held_q.delete();
      end
    end
    req_valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses to %0d requests (%0d directed, the rest random).",
             rsp_checked, items_sent, DIRECTED_N);
    $display("Highest index found %0d, %0d finds saw none free, input held %0d cycles.",
             top_found, finds_none, input_blocked);
    if (fault_count == 0) begin
      $display("tb_free_cluster_bitmap passed");
    end else begin
      $display("%0d faulty responses", fault_count);
      $display("tb_free_cluster_bitmap failed");
    end
    $finish;
  end

endmodule
